// File: rtl/core/wav_hp_pkg.sv
// ----------------------------------------------------------------------------
// wav_hp_pkg
// shared types and constants for the riff/wave pcm header parser
// ----------------------------------------------------------------------------
package wav_hp_pkg;

    localparam int FMT_CAPTURE_BYTES = 16;
    localparam int FMT_IDX_W         = $clog2(FMT_CAPTURE_BYTES);

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN   = 32'd16;
    localparam logic [32:0] CHUNK_HDR = 33'd8;
    localparam logic [33:0] FILE_HDR  = 34'd12;
    localparam logic [33:0] POS_MAX   = 34'h3_FFFF_FFFF;
    localparam logic [31:0] MAX_SAMPLES_RESET = 32'd65536;

    localparam logic [4:0] MUL_STEPS = 5'd15;
    localparam logic [4:0] DIV_STEPS = 5'd31;

    // result status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SMALL     = 4'd1;
    localparam logic [3:0] ST_RIFF      = 4'd2;
    localparam logic [3:0] ST_WAVE      = 4'd3;
    localparam logic [3:0] ST_SIZE      = 4'd4;
    localparam logic [3:0] ST_FMT_SMALL = 4'd5;
    localparam logic [3:0] ST_NO_FMT    = 4'd6;
    localparam logic [3:0] ST_NO_DATA   = 4'd7;
    localparam logic [3:0] ST_FORMAT    = 4'd8;
    localparam logic [3:0] ST_BPS       = 4'd9;
    localparam logic [3:0] ST_CH        = 4'd10;
    localparam logic [3:0] ST_RATE      = 4'd11;
    localparam logic [3:0] ST_ALIGN     = 4'd12;
    localparam logic [3:0] ST_BYTERATE  = 4'd13;
    localparam logic [3:0] ST_EMPTY     = 4'd14;

    typedef enum logic [2:0] {
        PH_FILE,
        PH_CHDR,
        PH_BODY,
        PH_STOP,
        PH_DATA
    } t_phase;

    typedef enum logic [2:0] {
        SQ_FEED,
        SQ_CHECK,
        SQ_BRATE,
        SQ_DIV,
        SQ_SPAN,
        SQ_DONE
    } t_seq;

endpackage

// File: rtl/core/wav_header_parser.sv
// ----------------------------------------------------------------------------
// wav_header_parser
// byte-wide riff/wave pcm header parser with one shared add/subtract unit
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  file byte, tlast on final
// m_axis    out        m_axis_tvalid/m_axis_tready  one result per buffer
// cfg       in         i_cfg_valid/o_cfg_ready      max_samples
//
// one byte a cycle while s_axis_tready is high; after the final byte the block
// is busy on a good header (check, byte-rate multiply, divide, span multiply,
// hand-over) on the shared shift-add/subtract unit; errors skip ahead.
// reset is synchronous, clears all parse state and sets the limit to 65536.
// a finished result waits in its output register while the next buffer flows.
// ----------------------------------------------------------------------------
module wav_header_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // channel_count, sample_rate, frame_bytes, sample_bits, frame_count,
    // data_start, sample_span_bytes, zero fill
    output logic [183:0] m_axis_tdata,
    output logic [7:0]   m_axis_tuser,   // status, was_clamped, zero fill
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data
);
    import wav_hp_pkg::*;

    // parse state
    t_phase       r_phase, n_phase;
    logic [33:0]  r_pos, n_pos;
    logic [33:0]  r_walk_end, n_walk_end;
    logic [63:0]  r_shift, n_shift;
    logic [32:0]  r_skip, n_skip;
    logic [7:0]   r_fmt [FMT_CAPTURE_BYTES];
    logic [7:0]   n_fmt [FMT_CAPTURE_BYTES];
    logic         r_fmt_present, n_fmt_present;
    logic [31:0]  r_data_len, n_data_len;
    logic [3:0]   r_err, n_err;
    logic [31:0]  r_max, n_max;

    // sequencer and shared unit
    t_seq         r_seq, n_seq;
    logic [31:0]  r_acc, n_acc;
    logic [31:0]  r_opa, n_opa;
    logic [31:0]  r_opb, n_opb;
    logic [4:0]   r_cnt, n_cnt;
    logic [3:0]   r_status, n_status;
    logic [31:0]  r_frames, n_frames;
    logic         r_clamped, n_clamped;

    // output register
    logic         r_ovalid, n_ovalid;
    logic [3:0]   r_o_status, n_o_status;
    logic [15:0]  r_o_ch, n_o_ch;
    logic [31:0]  r_o_rate, n_o_rate;
    logic [15:0]  r_o_align, n_o_align;
    logic [15:0]  r_o_bps, n_o_bps;
    logic [31:0]  r_o_frames, n_o_frames;
    logic         r_o_clamped, n_o_clamped;
    logic [33:0]  r_o_start, n_o_start;
    logic [31:0]  r_o_span, n_o_span;

    logic         feed;
    logic [63:0]  shift_new;
    logic [31:0]  id_new, size_new;
    logic [34:0]  pos_next;
    logic         walk_ok;
    logic [33:0]  riff_size;
    logic [32:0]  skip_dec;
    logic [32:0]  body_idx;

    logic [15:0]  f_fmtc, f_ch, f_align, f_bps;
    logic [31:0]  f_rate, f_brate;
    logic [18:0]  align_expect;
    logic [3:0]   chk_status;

    logic         is_div;
    logic [32:0]  div_shifted;
    logic [33:0]  op_x, op_y, sum;
    logic         div_ge;
    logic [31:0]  mul_acc_next;
    logic [31:0]  quotient;
    logic         cnt_zero;
    logic         brate_bad;
    logic         done_load;

    // ------------------------------------------------------------------------
    // byte feed helpers
    // ------------------------------------------------------------------------
    assign feed      = (r_seq == SQ_FEED) && s_axis_tvalid;
    assign shift_new = {s_axis_tdata, r_shift[63:8]};
    assign id_new    = shift_new[31:0];
    assign size_new  = shift_new[63:32];
    assign pos_next  = {1'b0, r_pos} + 35'd1;
    assign walk_ok   = (pos_next + 35'd8) <= {1'b0, r_walk_end};
    assign riff_size = r_walk_end - 34'd8;
    assign skip_dec  = r_skip - 33'd1;
    assign body_idx  = {1'b0, r_shift[63:32]} - r_skip;

    // ------------------------------------------------------------------------
    // fmt field checks
    // ------------------------------------------------------------------------
    assign f_fmtc  = {r_fmt[1], r_fmt[0]};
    assign f_ch    = {r_fmt[3], r_fmt[2]};
    assign f_rate  = {r_fmt[7], r_fmt[6], r_fmt[5], r_fmt[4]};
    assign f_brate = {r_fmt[11], r_fmt[10], r_fmt[9], r_fmt[8]};
    assign f_align = {r_fmt[13], r_fmt[12]};
    assign f_bps   = {r_fmt[15], r_fmt[14]};
    assign align_expect = {3'b000, f_ch} * {16'd0, f_bps[5:3]};

    always_comb begin
        if (r_pos < FILE_HDR) begin
            chk_status = ST_SMALL;
        end else if (r_err != ST_OK) begin
            chk_status = r_err;
        end else if (!r_fmt_present) begin
            chk_status = ST_NO_FMT;
        end else if (r_phase != PH_DATA) begin
            chk_status = ST_NO_DATA;
        end else if (f_fmtc != 16'd1) begin
            chk_status = ST_FORMAT;
        end else if (f_bps != 16'd16 && f_bps != 16'd24 && f_bps != 16'd32) begin
            chk_status = ST_BPS;
        end else if (f_ch == 16'd0) begin
            chk_status = ST_CH;
        end else if (f_rate == 32'd0) begin
            chk_status = ST_RATE;
        end else if ({3'b000, f_align} != align_expect) begin
            chk_status = ST_ALIGN;
        end else begin
            chk_status = ST_OK;
        end
    end

    // ------------------------------------------------------------------------
    // shared add/subtract unit: shift-add multiply or restoring divide step
    // ------------------------------------------------------------------------
    assign is_div       = (r_seq == SQ_DIV);
    assign div_shifted  = {r_acc, r_opb[31]};
    assign op_x         = is_div ? {1'b0, div_shifted} : {2'b00, r_acc};
    assign op_y         = is_div ? ~{18'd0, f_align} : {2'b00, r_opa};
    assign sum          = op_x + op_y + {33'd0, is_div};
    assign div_ge       = !sum[33];
    assign mul_acc_next = r_opb[0] ? sum[31:0] : r_acc;
    assign quotient     = {r_opb[30:0], div_ge};
    assign cnt_zero     = (r_cnt == 5'd0);
    assign brate_bad    = (f_brate != mul_acc_next);
    assign done_load    = (r_seq == SQ_DONE) && (!r_ovalid || m_axis_tready);

    // ------------------------------------------------------------------------
    // sequencer next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_FEED: begin
                if (feed && s_axis_tlast) begin
                    n_seq = SQ_CHECK;
                end
            end
            SQ_CHECK: begin
                n_seq = (chk_status != ST_OK) ? SQ_DONE : SQ_BRATE;
            end
            SQ_BRATE: begin
                if (cnt_zero) begin
                    n_seq = (brate_bad || r_data_len == 32'd0) ? SQ_DONE : SQ_DIV;
                end
            end
            SQ_DIV: begin
                if (cnt_zero) begin
                    n_seq = SQ_SPAN;
                end
            end
            SQ_SPAN: begin
                if (cnt_zero) begin
                    n_seq = SQ_DONE;
                end
            end
            SQ_DONE: begin
                if (done_load) begin
                    n_seq = SQ_FEED;
                end
            end
            default: n_seq = SQ_FEED;
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer outputs
    // ------------------------------------------------------------------------
    always_comb begin
        s_axis_tready = (r_seq == SQ_FEED);
        m_axis_tvalid = r_ovalid;
        o_cfg_ready   = 1'b1;
        m_axis_tdata  = {6'd0, r_o_span, r_o_start, r_o_frames, r_o_bps,
                         r_o_align, r_o_rate, r_o_ch};
        m_axis_tuser  = {3'd0, r_o_clamped, r_o_status};
    end

    // ------------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------------
    always_comb begin
        n_phase       = r_phase;
        n_pos         = r_pos;
        n_walk_end    = r_walk_end;
        n_shift       = r_shift;
        n_skip        = r_skip;
        n_fmt         = r_fmt;
        n_fmt_present = r_fmt_present;
        n_data_len    = r_data_len;
        n_err         = r_err;
        n_max         = r_max;
        n_acc         = r_acc;
        n_opa         = r_opa;
        n_opb         = r_opb;
        n_cnt         = r_cnt;
        n_status      = r_status;
        n_frames      = r_frames;
        n_clamped     = r_clamped;
        n_ovalid      = r_ovalid && !m_axis_tready;
        n_o_status    = r_o_status;
        n_o_ch        = r_o_ch;
        n_o_rate      = r_o_rate;
        n_o_align     = r_o_align;
        n_o_bps       = r_o_bps;
        n_o_frames    = r_o_frames;
        n_o_clamped   = r_o_clamped;
        n_o_start     = r_o_start;
        n_o_span      = r_o_span;

        if (i_cfg_valid) begin
            n_max = i_cfg_data;
        end

        if (feed) begin
            if (r_pos != POS_MAX) begin
                n_pos = pos_next[33:0];
            end
            unique case (r_phase)
                PH_FILE: begin
                    n_shift = shift_new;
                    if (r_pos == 34'd7) begin
                        if (id_new != ID_RIFF) begin
                            n_err   = ST_RIFF;
                            n_phase = PH_STOP;
                        end else begin
                            n_walk_end = {2'b00, size_new} + 34'd8;
                        end
                    end else if (r_pos == FILE_HDR - 34'd1) begin
                        if (size_new != ID_WAVE) begin
                            n_err   = ST_WAVE;
                            n_phase = PH_STOP;
                        end else if (riff_size < 34'd4 || riff_size > 34'hFFFF_FFF7) begin
                            n_err   = ST_SIZE;
                            n_phase = PH_STOP;
                        end else begin
                            n_phase = walk_ok ? PH_CHDR : PH_STOP;
                            n_skip  = CHUNK_HDR;
                        end
                    end
                end
                PH_CHDR: begin
                    n_shift = shift_new;
                    n_skip  = skip_dec;
                    if (skip_dec == 33'd0) begin
                        if (id_new == ID_FMT && size_new < FMT_MIN) begin
                            n_err   = ST_FMT_SMALL;
                            n_phase = PH_STOP;
                        end else if (id_new == ID_DATA) begin
                            n_data_len = size_new;
                            n_walk_end = pos_next[33:0];
                            n_phase    = PH_DATA;
                        end else begin
                            if (id_new == ID_FMT) begin
                                for (int i = 0; i < FMT_CAPTURE_BYTES; i++) begin
                                    n_fmt[i] = 8'd0;
                                end
                                n_fmt_present = 1'b1;
                            end
                            if (size_new == 32'd0) begin
                                n_phase = walk_ok ? PH_CHDR : PH_STOP;
                                n_skip  = CHUNK_HDR;
                            end else begin
                                n_phase = PH_BODY;
                                n_skip  = {1'b0, size_new};
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (r_shift[31:0] == ID_FMT &&
                        body_idx < 33'(FMT_CAPTURE_BYTES)) begin
                        n_fmt[body_idx[FMT_IDX_W-1:0]] = s_axis_tdata;
                    end
                    n_skip = skip_dec;
                    if (skip_dec == 33'd0) begin
                        n_phase = walk_ok ? PH_CHDR : PH_STOP;
                        n_skip  = CHUNK_HDR;
                    end
                end
                default: begin
                end
            endcase
        end

        case (r_seq)
            SQ_CHECK: begin
                n_status = chk_status;
                n_acc    = 32'd0;
                n_opa    = f_rate;
                n_opb    = {16'd0, f_align};
                n_cnt    = MUL_STEPS;
            end
            SQ_BRATE: begin
                n_acc = mul_acc_next;
                n_opa = {r_opa[30:0], 1'b0};
                n_opb = {1'b0, r_opb[31:1]};
                n_cnt = r_cnt - 5'd1;
                if (cnt_zero) begin
                    if (brate_bad) begin
                        n_status = ST_BYTERATE;
                    end else if (r_data_len == 32'd0) begin
                        n_status = ST_EMPTY;
                    end
                    n_acc = 32'd0;
                    n_opb = r_data_len;
                    n_cnt = DIV_STEPS;
                end
            end
            SQ_DIV: begin
                n_acc = div_ge ? sum[31:0] : div_shifted[31:0];
                n_opb = quotient;
                n_cnt = r_cnt - 5'd1;
                if (cnt_zero) begin
                    if (quotient > r_max) begin
                        n_frames  = r_max;
                        n_clamped = 1'b1;
                        n_opa     = r_max;
                    end else begin
                        n_frames  = quotient;
                        n_clamped = 1'b0;
                        n_opa     = quotient;
                    end
                    n_acc = 32'd0;
                    n_opb = {16'd0, f_align};
                    n_cnt = MUL_STEPS;
                end
            end
            SQ_SPAN: begin
                n_acc = mul_acc_next;
                n_opa = {r_opa[30:0], 1'b0};
                n_opb = {1'b0, r_opb[31:1]};
                n_cnt = r_cnt - 5'd1;
            end
            SQ_DONE: begin
                if (done_load) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    if (r_status == ST_OK) begin
                        n_o_ch      = f_ch;
                        n_o_rate    = f_rate;
                        n_o_align   = f_align;
                        n_o_bps     = f_bps;
                        n_o_frames  = r_frames;
                        n_o_clamped = r_clamped;
                        n_o_start   = r_walk_end;
                        n_o_span    = r_acc;
                    end else begin
                        n_o_ch      = 16'd0;
                        n_o_rate    = 32'd0;
                        n_o_align   = 16'd0;
                        n_o_bps     = 16'd0;
                        n_o_frames  = 32'd0;
                        n_o_clamped = 1'b0;
                        n_o_start   = 34'd0;
                        n_o_span    = 32'd0;
                    end
                    // fresh parse state for the next buffer
                    n_phase       = PH_FILE;
                    n_pos         = 34'd0;
                    n_walk_end    = 34'd0;
                    n_shift       = 64'd0;
                    n_skip        = 33'd0;
                    for (int i = 0; i < FMT_CAPTURE_BYTES; i++) begin
                        n_fmt[i] = 8'd0;
                    end
                    n_fmt_present = 1'b0;
                    n_data_len    = 32'd0;
                    n_err         = ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq         <= SQ_FEED;
            r_phase       <= PH_FILE;
            r_pos         <= 34'd0;
            r_walk_end    <= 34'd0;
            r_shift       <= 64'd0;
            r_skip        <= 33'd0;
            for (int i = 0; i < FMT_CAPTURE_BYTES; i++) begin
                r_fmt[i] <= 8'd0;
            end
            r_fmt_present <= 1'b0;
            r_data_len    <= 32'd0;
            r_err         <= ST_OK;
            r_max         <= MAX_SAMPLES_RESET;
            r_ovalid      <= 1'b0;
        end else begin
            r_seq         <= n_seq;
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_walk_end    <= n_walk_end;
            r_shift       <= n_shift;
            r_skip        <= n_skip;
            r_fmt         <= n_fmt;
            r_fmt_present <= n_fmt_present;
            r_data_len    <= n_data_len;
            r_err         <= n_err;
            r_max         <= n_max;
            r_ovalid      <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_opa       <= n_opa;
        r_opb       <= n_opb;
        r_cnt       <= n_cnt;
        r_status    <= n_status;
        r_frames    <= n_frames;
        r_clamped   <= n_clamped;
        r_o_status  <= n_o_status;
        r_o_ch      <= n_o_ch;
        r_o_rate    <= n_o_rate;
        r_o_align   <= n_o_align;
        r_o_bps     <= n_o_bps;
        r_o_frames  <= n_o_frames;
        r_o_clamped <= n_o_clamped;
        r_o_start   <= n_o_start;
        r_o_span    <= n_o_span;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken while a buffer is being finished");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_seq == SQ_DONE))
        else $error("result raised outside the hand-over step");

    a_ok_has_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_o_status == ST_OK) |-> (r_o_align != 16'd0))
        else $error("good result with zero block align");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_o_status != ST_OK) |->
            (r_o_frames == 32'd0 && r_o_start == 34'd0 && r_o_span == 32'd0))
        else $error("error result carries payload");

    a_clamp_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_o_clamped) |-> (r_o_frames == r_max))
        else $error("clamped count differs from the limit");

endmodule
